// ===== design/depth_pixel_backprojection_assert.svh =====
// ----------------------------------------------------------------------------
// depth pixel back-projection assertion macros
// shared forms for the concurrent checks of the block
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH

// checked only outside reset
`define DPB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define DPB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/dpb_pkg.sv =====
// ----------------------------------------------------------------------------
// dpb_pkg
// types, register map and constants of the depth pixel back-projection block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpb_pkg;

    localparam int MAX_IMAGE_DIM = 4096;
    localparam int DIM_CMP_W     = 17;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INV_DEPTH_SCALE,
        CFG_INV_FOCAL_X,
        CFG_INV_FOCAL_Y,
        CFG_PRINCIPAL_POINT,
        CFG_POSE_ROW_X,
        CFG_POSE_ROW_Y,
        CFG_POSE_ROW_Z,
        CFG_DEPTH_LIMIT
    } cfg_index_t;

    localparam logic [31:0] INV_DEPTH_SCALE_RESET = 32'd858993;
    localparam logic [31:0] INV_FOCAL_X_RESET     = 32'd8302662;
    localparam logic [31:0] INV_FOCAL_Y_RESET     = 32'd8315522;
    localparam logic [31:0] PRINCIPAL_POINT_RESET = 32'd267719658;
    localparam logic [63:0] POSE_ROW_X_RESET      = 64'h0000_0000_0000_4000;
    localparam logic [63:0] POSE_ROW_Y_RESET      = 64'h0000_0000_4000_0000;
    localparam logic [63:0] POSE_ROW_Z_RESET      = 64'h0000_4000_0000_0000;
    localparam logic [15:0] DEPTH_LIMIT_RESET     = 16'd7000;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } colour_t;

    typedef struct packed {
        colour_t     colour;
        logic [15:0] depth_raw;
        logic [11:0] row_index;
        logic [11:0] column;
    } pixel_t;

    typedef struct packed {
        logic [31:0]      inv_depth_scale;
        logic [31:0]      inv_focal_x;
        logic [31:0]      inv_focal_y;
        logic [15:0]      cy;
        logic [15:0]      cx;
        logic [2:0][63:0] pose;
        logic [15:0]      depth_limit;
    } cfg_t;

    // camera depth and scaled offsets
    typedef struct packed {
        colour_t            colour;
        logic [32:0]        z16;
        logic signed [29:0] a;
        logic signed [29:0] b;
    } front_t;

    // camera-frame point, Q.16
    typedef struct packed {
        colour_t            colour;
        logic [32:0]        z16;
        logic signed [46:0] x;
        logic signed [46:0] y;
    } lateral_t;

    typedef struct packed {
        colour_t            colour;
        logic signed [31:0] world_z;
        logic signed [31:0] world_y;
        logic signed [31:0] world_x;
    } result_t;

endpackage

// ===== design/dpb_front.sv =====
// ----------------------------------------------------------------------------
// dpb_front
// pixel gating, depth scaling and reciprocal-focal products (three stages)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpb_front import dpb_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  pixel_t in_pix,
    output logic   out_valid,
    input  logic   out_ready,
    output front_t out_data
);

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic               s1_en, s2_en, s3_en;

    logic signed [16:0] s1_du_reg, s1_dv_reg;
    logic [15:0]        s1_depth_reg;
    colour_t            s1_colour_reg;

    logic [47:0]        s2_z_prod_reg;
    logic signed [49:0] s2_a_prod_reg, s2_b_prod_reg;
    colour_t            s2_colour_reg;

    front_t             s3_data_reg;

    logic               pass_next;
    logic signed [16:0] du_next, dv_next;
    logic [47:0]        z_prod_next;
    logic signed [49:0] a_prod_next, b_prod_next;
    logic [48:0]        z_sum;
    logic [49:0]        a_sum, b_sum;
    front_t             data_next;

    assign s3_en    = !s3_valid_reg || out_ready;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    always_comb begin
        pass_next = (in_pix.depth_raw != '0) && (in_pix.depth_raw < cfg.depth_limit)
                    && (DIM_CMP_W'(in_pix.column) < DIM_CMP_W'(MAX_IMAGE_DIM))
                    && (DIM_CMP_W'(in_pix.row_index) < DIM_CMP_W'(MAX_IMAGE_DIM));
        du_next = $signed({1'b0, in_pix.column, 4'b0000}) - $signed({1'b0, cfg.cx});
        dv_next = $signed({1'b0, in_pix.row_index, 4'b0000}) - $signed({1'b0, cfg.cy});
    end

    always_comb begin
        z_prod_next = 48'(s1_depth_reg) * 48'(cfg.inv_depth_scale);
        a_prod_next = s1_du_reg * $signed({1'b0, cfg.inv_focal_x});
        b_prod_next = s1_dv_reg * $signed({1'b0, cfg.inv_focal_y});
    end

    // round half away from zero
    always_comb begin
        z_sum = 49'(s2_z_prod_reg) + 49'(2**15);
        a_sum = s2_a_prod_reg + 50'(2**19) - 50'(s2_a_prod_reg[49]);
        b_sum = s2_b_prod_reg + 50'(2**19) - 50'(s2_b_prod_reg[49]);
        data_next.colour = s2_colour_reg;
        data_next.z16    = z_sum[48:16];
        data_next.a      = a_sum[49:20];
        data_next.b      = b_sum[49:20];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_en) begin
                s1_valid_reg <= in_valid && pass_next;
            end
            if (s2_en) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_en) begin
            s1_du_reg     <= du_next;
            s1_dv_reg     <= dv_next;
            s1_depth_reg  <= in_pix.depth_raw;
            s1_colour_reg <= in_pix.colour;
        end
        if (s2_en) begin
            s2_z_prod_reg <= z_prod_next;
            s2_a_prod_reg <= a_prod_next;
            s2_b_prod_reg <= b_prod_next;
            s2_colour_reg <= s1_colour_reg;
        end
        if (s3_en) begin
            s3_data_reg <= data_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

// ===== design/dpb_lateral.sv =====
// ----------------------------------------------------------------------------
// dpb_lateral
// camera-frame x and y from scaled offsets and depth (two stages)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpb_lateral import dpb_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  front_t   in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output lateral_t out_data
);

    logic               s4_valid_reg, s5_valid_reg;
    logic               s4_en, s5_en;

    logic signed [63:0] s4_px_reg, s4_py_reg;
    logic [32:0]        s4_z_reg;
    colour_t            s4_colour_reg;
    lateral_t           s5_data_reg;

    logic signed [63:0] px_next, py_next;
    logic [63:0]        x_sum, y_sum;
    lateral_t           data_next;

    assign s5_en    = !s5_valid_reg || out_ready;
    assign s4_en    = !s4_valid_reg || s5_en;
    assign in_ready = s4_en;

    always_comb begin
        px_next = $signed(in_data.a) * $signed({1'b0, in_data.z16});
        py_next = $signed(in_data.b) * $signed({1'b0, in_data.z16});
    end

    always_comb begin
        x_sum = s4_px_reg + 64'(2**15) - 64'(s4_px_reg[63]);
        y_sum = s4_py_reg + 64'(2**15) - 64'(s4_py_reg[63]);
        data_next.colour = s4_colour_reg;
        data_next.z16    = s4_z_reg;
        data_next.x      = x_sum[62:16];
        data_next.y      = y_sum[62:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            if (s4_en) begin
                s4_valid_reg <= in_valid;
            end
            if (s5_en) begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_en) begin
            s4_px_reg     <= px_next;
            s4_py_reg     <= py_next;
            s4_z_reg      <= in_data.z16;
            s4_colour_reg <= in_data.colour;
        end
        if (s5_en) begin
            s5_data_reg <= data_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_data  = s5_data_reg;

endmodule

// ===== design/dpb_pose.sv =====
// ----------------------------------------------------------------------------
// dpb_pose
// rigid pose transform, rounding and saturation to Q16.16 (three stages)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpb_pose import dpb_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_ready,
    input  lateral_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_data
);

    logic               s6_valid_reg, s7_valid_reg, s8_valid_reg;
    logic               s6_en, s7_en, s8_en;

    logic signed [62:0] s6_px_reg [3];
    logic signed [62:0] s6_py_reg [3];
    logic signed [49:0] s6_pz_reg [3];
    colour_t            s6_colour_reg;

    logic signed [63:0] s7_acc_reg [3];
    colour_t            s7_colour_reg;

    result_t            s8_data_reg;

    logic signed [62:0] px_next [3];
    logic signed [62:0] py_next [3];
    logic signed [49:0] pz_next [3];
    logic signed [63:0] acc_next [3];
    logic [63:0]        rnd_sum [3];
    logic [49:0]        rnd_q [3];
    logic [31:0]        w_next [3];
    result_t            data_next;

    assign s8_en    = !s8_valid_reg || out_ready;
    assign s7_en    = !s7_valid_reg || s8_en;
    assign s6_en    = !s6_valid_reg || s7_en;
    assign in_ready = s6_en;

    // one lane per pose row
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            px_next[i] = $signed(cfg.pose[i][15:0]) * in_data.x;
            py_next[i] = $signed(cfg.pose[i][31:16]) * in_data.y;
            pz_next[i] = $signed(cfg.pose[i][47:32]) * $signed({1'b0, in_data.z16});
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc_next[i] = 64'(s6_px_reg[i]) + 64'(s6_py_reg[i]) + 64'(s6_pz_reg[i])
                        + (64'($signed(cfg.pose[i][63:48])) <<< 22);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd_sum[i] = s7_acc_reg[i] + 64'(2**13) - 64'(s7_acc_reg[i][63]);
            rnd_q[i]   = rnd_sum[i][63:14];
            if ((rnd_q[i][49:31] == '0) || (rnd_q[i][49:31] == '1)) begin
                w_next[i] = rnd_q[i][31:0];
            end else if (rnd_q[i][49]) begin
                w_next[i] = SAT_MIN;
            end else begin
                w_next[i] = SAT_MAX;
            end
        end
        data_next.colour  = s7_colour_reg;
        data_next.world_x = w_next[0];
        data_next.world_y = w_next[1];
        data_next.world_z = w_next[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end else begin
            if (s6_en) begin
                s6_valid_reg <= in_valid;
            end
            if (s7_en) begin
                s7_valid_reg <= s6_valid_reg;
            end
            if (s8_en) begin
                s8_valid_reg <= s7_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s6_en) begin
            s6_px_reg     <= px_next;
            s6_py_reg     <= py_next;
            s6_pz_reg     <= pz_next;
            s6_colour_reg <= in_data.colour;
        end
        if (s7_en) begin
            s7_acc_reg    <= acc_next;
            s7_colour_reg <= s6_colour_reg;
        end
        if (s8_en) begin
            s8_data_reg <= data_next;
        end
    end

    assign out_valid = s8_valid_reg;
    assign out_data  = s8_data_reg;

endmodule

// ===== design/depth_pixel_backprojection.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// RGB-D pixel to coloured world point, pinhole back-projection plus pose
// ----------------------------------------------------------------------------
// s_ channel takes one pixel per transfer: column, row, raw depth and colour.
// m_ channel gives one world point per kept pixel, Q16.16 metres, saturated,
// with the colour bytes unchanged. Pixels with zero depth, depth at or above
// the limit, or outside the image produce no transfer on m_.
// Camera and pose registers are written on the cfg_ port and take effect at
// the next edge; the user must write them while no pixel is in flight, as
// the block does not enforce it. A pixel passes eight register stages
// from the s_ transfer to m_ (gate, products, rounding, lateral products,
// rounding, pose products, sum, round and saturate). One pixel is taken
// every cycle unless m_ stalls. Each stage moves on when its successor is
// empty or moving, so a stall on m_tready fills the bubbles first and then
// holds s_tready low; nothing is lost or repeated. Reset clears all stage
// valid bits and loads the default camera model with an identity pose.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module depth_pixel_backprojection import dpb_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // column, row_index, depth_raw, blue, green, red
    input  logic [63:0]            s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // world_x, world_y, world_z, out_blue, out_green, out_red
    output logic [119:0]           m_tdata
);

    cfg_t     cfg_reg;
    logic     front_valid, front_ready;
    front_t   front_data;
    logic     lat_valid, lat_ready;
    lateral_t lat_data;
    result_t  result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inv_depth_scale <= INV_DEPTH_SCALE_RESET;
            cfg_reg.inv_focal_x     <= INV_FOCAL_X_RESET;
            cfg_reg.inv_focal_y     <= INV_FOCAL_Y_RESET;
            cfg_reg.cx              <= PRINCIPAL_POINT_RESET[15:0];
            cfg_reg.cy              <= PRINCIPAL_POINT_RESET[31:16];
            cfg_reg.pose[0]         <= POSE_ROW_X_RESET;
            cfg_reg.pose[1]         <= POSE_ROW_Y_RESET;
            cfg_reg.pose[2]         <= POSE_ROW_Z_RESET;
            cfg_reg.depth_limit     <= DEPTH_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_INV_DEPTH_SCALE: cfg_reg.inv_depth_scale <= cfg_wdata[31:0];
                CFG_INV_FOCAL_X:     cfg_reg.inv_focal_x     <= cfg_wdata[31:0];
                CFG_INV_FOCAL_Y:     cfg_reg.inv_focal_y     <= cfg_wdata[31:0];
                CFG_PRINCIPAL_POINT: begin
                    cfg_reg.cx <= cfg_wdata[15:0];
                    cfg_reg.cy <= cfg_wdata[31:16];
                end
                CFG_POSE_ROW_X:      cfg_reg.pose[0]     <= cfg_wdata;
                CFG_POSE_ROW_Y:      cfg_reg.pose[1]     <= cfg_wdata;
                CFG_POSE_ROW_Z:      cfg_reg.pose[2]     <= cfg_wdata;
                CFG_DEPTH_LIMIT:     cfg_reg.depth_limit <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    dpb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (pixel_t'(s_tdata)),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    dpb_lateral u_lateral (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (lat_valid),
        .out_ready (lat_ready),
        .out_data  (lat_data)
    );

    dpb_pose u_pose (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (lat_valid),
        .in_ready  (lat_ready),
        .in_data   (lat_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tdata = result;

endmodule

// ===== design/dpb_checker.sv =====
// ----------------------------------------------------------------------------
// dpb_checker
// port-level checks of the back-projection block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "depth_pixel_backprojection_assert.svh"

module dpb_checker import dpb_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   cfg_wr_en,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_wdata,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [63:0]            s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [119:0]           m_tdata
);

    logic [15:0] limit_reg;
    logic [7:0]  flow_hist_reg;
    logic        flow_full;
    logic        s_xfer;
    logic        keep;
    pixel_t      pix;

    assign pix       = pixel_t'(s_tdata);
    assign s_xfer    = s_tvalid && s_tready;
    assign flow_full = &flow_hist_reg;
    assign keep      = (pix.depth_raw != '0) && (pix.depth_raw < limit_reg)
                       && (DIM_CMP_W'(pix.column) < DIM_CMP_W'(MAX_IMAGE_DIM))
                       && (DIM_CMP_W'(pix.row_index) < DIM_CMP_W'(MAX_IMAGE_DIM));

    // m_tready history, so a pixel's path is known to be free of stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= DEPTH_LIMIT_RESET;
            flow_hist_reg <= '0;
        end else begin
            flow_hist_reg <= {flow_hist_reg[6:0], m_tready};
            if (cfg_wr_en && (cfg_index_t'(cfg_index) == CFG_DEPTH_LIMIT)) begin
                limit_reg <= cfg_wdata[15:0];
            end
        end
    end

    `DPB_ASSERT_ALWAYS(a_reset_clears_output, !aresetn |=> !m_tvalid, "m_tvalid after reset")

    `DPB_ASSERT(a_stall_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled transfer changed")

    `DPB_ASSERT(a_dropped_pixel, flow_full && $past(s_xfer && !keep, 8) |-> !m_tvalid, "dropped pixel gave a result")

    `DPB_ASSERT(a_kept_pixel, flow_full && $past(s_xfer && keep, 8) |-> m_tvalid && (m_tdata[119:96] == $past(s_tdata[63:40], 8)), "kept pixel lost or colour changed")

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (.*);

// ===== dv/tb_depth_pixel_backprojection.sv =====
// ----------------------------------------------------------------------------
// tb_depth_pixel_backprojection
// self-checking bench for the RGB-D pixel to world point back-projection
// ----------------------------------------------------------------------------
// Pixels go in on the s_ stream and coloured world points come out on m_.
// A predictor in the bench computes each point at the moment its pixel is
// accepted, using its own copy of the camera registers, and keeps the points
// in order. Every m_ transfer is checked field by field against the oldest
// predicted point. Directed tests cover the register defaults, depth edges,
// register extremes and saturation; random tests then run under changing
// camera setups with sender gaps and receiver stalls, and a long receiver
// hold-off forces the pipeline to fill and stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_depth_pixel_backprojection import dpb_pkg::*; ();

    localparam int unsigned PIPE_LATENCY = 8;
    localparam int unsigned DRAIN_LIMIT  = 20000;

    typedef struct packed {
        logic [31:0]      depth_scale_recip;
        logic [31:0]      focal_x_recip;
        logic [31:0]      focal_y_recip;
        logic [15:0]      cx;
        logic [15:0]      cy;
        logic [2:0][63:0] pose;
        logic [15:0]      depth_limit;
    } camera_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    pixel_t                 s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [119:0]           m_tdata;

    camera_t     cam;
    result_t     expected_points[$];
    int unsigned fail_count;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned hold_left;

    depth_pixel_backprojection dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic longint round_half_away(longint v, int unsigned sh);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic logic [31:0] clamp_q16(longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return SAT_MAX;
        if (v < -longint'(64'sh8000_0000))
            return SAT_MIN;
        return v[31:0];
    endfunction

    function automatic longint pose_entry(logic [63:0] row, int unsigned slot);
        return longint'($signed(row[16*slot +: 16]));
    endfunction

    function automatic logic [31:0] world_coord(logic [63:0] row, longint x, longint y,
                                                longint z);
        longint acc;
        acc = pose_entry(row, 0) * x + pose_entry(row, 1) * y + pose_entry(row, 2) * z
            + pose_entry(row, 3) * (longint'(1) << 22);
        return clamp_q16(round_half_away(acc, 14));
    endfunction

    // returns 1 and the point when the pixel is kept
    function automatic bit backproject(pixel_t px, output result_t pt);
        longint z16, du, dv, x, y;
        pt = '0;
        if (px.depth_raw == 0 || px.depth_raw >= cam.depth_limit)
            return 0;
        if (px.column >= MAX_IMAGE_DIM || px.row_index >= MAX_IMAGE_DIM)
            return 0;
        z16 = (longint'(px.depth_raw) * longint'(cam.depth_scale_recip) + 32768) >>> 16;
        du  = longint'(px.column) * 16 - longint'(cam.cx);
        dv  = longint'(px.row_index) * 16 - longint'(cam.cy);
        x   = round_half_away(round_half_away(du * longint'(cam.focal_x_recip), 20) * z16, 16);
        y   = round_half_away(round_half_away(dv * longint'(cam.focal_y_recip), 20) * z16, 16);
        pt.world_x = world_coord(cam.pose[0], x, y, z16);
        pt.world_y = world_coord(cam.pose[1], x, y, z16);
        pt.world_z = world_coord(cam.pose[2], x, y, z16);
        pt.colour  = px.colour;
        return 1;
    endfunction

    // ---------------- result side ----------------

    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : point_check
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata);
            if (expected_points.size() == 0) begin
                $error("point transfer with none expected: %h", m_tdata);
                fail_count++;
            end else begin
                want = expected_points.pop_front();
                check_field("world_x", want.world_x, got.world_x);
                check_field("world_y", want.world_y, got.world_y);
                check_field("world_z", want.world_z, got.world_z);
                check_field("out_blue", want.colour.blue, got.colour.blue);
                check_field("out_green", want.colour.green, got.colour.green);
                check_field("out_red", want.colour.red, got.colour.red);
            end
        end
    end

    // ---------------- pixel side and registers ----------------

    function automatic int unsigned sender_gap();
        int unsigned n;
        n = 0;
        while (n < 40 && $urandom_range(99) < sender_idle_pct)
            n++;
        return n;
    endfunction

    // starts and ends just after a falling edge
    task automatic send_pixel(pixel_t px);
        int unsigned gap;
        result_t pt;
        gap = sender_gap();
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = px;
        do @(posedge aclk); while (!s_tready);
        if (backproject(px, pt))
            expected_points.insert(expected_points.size(), pt);
        @(negedge aclk);
    endtask

    task automatic settle_pipeline();
        int unsigned guard;
        s_tvalid = 1'b0;
        guard = 0;
        while (expected_points.size() != 0 && guard < DRAIN_LIMIT) begin
            @(negedge aclk);
            guard++;
        end
        if (expected_points.size() != 0) begin
            $error("%0d points never arrived", expected_points.size());
            fail_count++;
            expected_points.delete();
        end
        // dropped pixels may still be in flight
        repeat (2 * PIPE_LATENCY) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [63:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_INV_DEPTH_SCALE: cam.depth_scale_recip = value[31:0];
            CFG_INV_FOCAL_X:     cam.focal_x_recip     = value[31:0];
            CFG_INV_FOCAL_Y:     cam.focal_y_recip     = value[31:0];
            CFG_PRINCIPAL_POINT: {cam.cy, cam.cx}      = value[31:0];
            CFG_POSE_ROW_X:      cam.pose[0]           = value;
            CFG_POSE_ROW_Y:      cam.pose[1]           = value;
            CFG_POSE_ROW_Z:      cam.pose[2]           = value;
            CFG_DEPTH_LIMIT:     cam.depth_limit       = value[15:0];
            default: ;
        endcase
    endtask

    task automatic load_camera(camera_t c);
        settle_pipeline();
        write_reg(CFG_INV_DEPTH_SCALE, 64'(c.depth_scale_recip));
        write_reg(CFG_INV_FOCAL_X, 64'(c.focal_x_recip));
        write_reg(CFG_INV_FOCAL_Y, 64'(c.focal_y_recip));
        write_reg(CFG_PRINCIPAL_POINT, 64'({c.cy, c.cx}));
        write_reg(CFG_POSE_ROW_X, c.pose[0]);
        write_reg(CFG_POSE_ROW_Y, c.pose[1]);
        write_reg(CFG_POSE_ROW_Z, c.pose[2]);
        write_reg(CFG_DEPTH_LIMIT, 64'(c.depth_limit));
    endtask

    task automatic set_idling(int unsigned s_pct, int unsigned r_pct);
        sender_idle_pct    = s_pct;
        receiver_stall_pct = r_pct;
    endtask

    function automatic pixel_t make_pixel(int unsigned u, int unsigned v, int unsigned d,
                                          int unsigned b, int unsigned g, int unsigned r);
        pixel_t p;
        p.column       = u[11:0];
        p.row_index    = v[11:0];
        p.depth_raw    = d[15:0];
        p.colour.blue  = b[7:0];
        p.colour.green = g[7:0];
        p.colour.red   = r[7:0];
        return p;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        int unsigned pick;
        p = pixel_t'({$urandom, $urandom});
        pick = $urandom_range(19);
        if (pick == 0)
            p.depth_raw = '0;
        else if (pick == 1)
            p.depth_raw = 16'($urandom_range(cam.depth_limit, 65535));
        else if (pick > 2 && cam.depth_limit > 1)
            p.depth_raw = 16'($urandom_range(1, cam.depth_limit - 1));
        return p;
    endfunction

    function automatic camera_t random_camera(bit lifelike);
        camera_t c;
        if (lifelike) begin
            c.depth_scale_recip = $urandom_range(200000, 2000000);
            c.focal_x_recip     = $urandom_range(3000000, 30000000);
            c.focal_y_recip     = $urandom_range(3000000, 30000000);
            c.cx                = 16'($urandom);
            c.cy                = 16'($urandom);
            for (int i = 0; i < 3; i++)
                c.pose[i] = {16'($urandom), 16'($urandom_range(0, 32768) - 16384),
                             16'($urandom_range(0, 32768) - 16384),
                             16'($urandom_range(0, 32768) - 16384)};
            c.depth_limit = 16'($urandom_range(256, 65535));
        end else begin
            c.depth_scale_recip = $urandom;
            c.focal_x_recip     = $urandom;
            c.focal_y_recip     = $urandom;
            {c.cy, c.cx}        = $urandom;
            for (int i = 0; i < 3; i++)
                c.pose[i] = {$urandom, $urandom};
            c.depth_limit = 16'($urandom);
        end
        return c;
    endfunction

    // ---------------- tests ----------------

    task automatic test_default_camera();
        set_idling(0, 0);
        send_pixel(make_pixel(0, 0, 1, 0, 0, 0));
        send_pixel(make_pixel(4095, 4095, 6999, 255, 255, 255));
        send_pixel(make_pixel(320, 240, 0, 1, 2, 3));
        send_pixel(make_pixel(320, 240, 7000, 4, 5, 6));
        send_pixel(make_pixel(320, 240, 65535, 7, 8, 9));
        send_pixel(make_pixel(2048, 1024, 3000, 8'hAA, 8'h55, 8'h0F));
        send_pixel(make_pixel(0, 4095, 6999, 8'h0F, 8'hF0, 8'h81));
        send_pixel(make_pixel(4095, 0, 1, 8'h7E, 8'h18, 8'hE7));
    endtask

    task automatic test_register_extremes();
        camera_t c;
        set_idling(0, 0);
        c = cam;
        c.depth_scale_recip = '1;
        c.focal_x_recip     = '1;
        c.focal_y_recip     = '1;
        c.cx                = '0;
        c.cy                = '0;
        c.depth_limit       = '1;
        load_camera(c);
        send_pixel(make_pixel(4095, 4095, 16'hFFFE, 8'h00, 8'hFF, 8'h00));
        send_pixel(make_pixel(0, 0, 16'hFFFF, 8'hFF, 8'h00, 8'hFF));
        send_pixel(make_pixel(1, 1, 1, 8'h12, 8'h34, 8'h56));

        // principal point far right and low: large negative lateral offsets
        c.cx = '1;
        c.cy = '1;
        load_camera(c);
        send_pixel(make_pixel(0, 0, 16'hFFFE, 8'h01, 8'h02, 8'h03));
        send_pixel(make_pixel(4095, 4095, 16'hFFFE, 8'h04, 8'h05, 8'h06));

        // extreme rotation and translation entries, saturating both ways
        c.pose[0] = {4{16'h7FFF}};
        c.pose[1] = {4{16'h8000}};
        c.pose[2] = {16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF};
        load_camera(c);
        send_pixel(make_pixel(0, 4095, 16'hFFFE, 8'h10, 8'h20, 8'h30));
        send_pixel(make_pixel(2048, 2048, 1, 8'h40, 8'h50, 8'h60));

        // everything zero: only the zero point, then depth limits of 0, 1 and 2
        c = '0;
        c.depth_limit = '1;
        load_camera(c);
        send_pixel(make_pixel(4095, 4095, 16'hFFFE, 8'hC3, 8'h3C, 8'h99));
        c.depth_limit = 16'd0;
        load_camera(c);
        send_pixel(make_pixel(100, 100, 1, 0, 0, 0));
        send_pixel(make_pixel(100, 100, 16'hFFFF, 0, 0, 0));
        c.depth_limit = 16'd1;
        load_camera(c);
        send_pixel(make_pixel(100, 100, 1, 0, 0, 0));
        c = random_camera(1'b1);
        c.depth_limit = 16'd2;
        load_camera(c);
        send_pixel(make_pixel(100, 100, 1, 8'h11, 8'h22, 8'h33));
    endtask

    task automatic test_random_traffic(int unsigned s_pct, int unsigned r_pct,
                                       int unsigned setups, int unsigned per_setup);
        for (int k = 0; k < setups; k++) begin
            load_camera(random_camera(k != setups - 1));
            set_idling(s_pct, r_pct);
            repeat (per_setup) send_pixel(random_pixel());
        end
    endtask

    task automatic test_output_backpressure();
        camera_t c;
        c = random_camera(1'b1);
        load_camera(c);
        set_idling(0, 0);
        hold_left = 250;
        repeat (40) send_pixel(random_pixel());
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_INV_DEPTH_SCALE;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        fail_count = 0;
        hold_left  = 0;
        set_idling(0, 0);

        cam.depth_scale_recip = INV_DEPTH_SCALE_RESET;
        cam.focal_x_recip     = INV_FOCAL_X_RESET;
        cam.focal_y_recip     = INV_FOCAL_Y_RESET;
        {cam.cy, cam.cx}      = PRINCIPAL_POINT_RESET;
        cam.pose[0]           = POSE_ROW_X_RESET;
        cam.pose[1]           = POSE_ROW_Y_RESET;
        cam.pose[2]           = POSE_ROW_Z_RESET;
        cam.depth_limit       = DEPTH_LIMIT_RESET;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_default_camera();
        test_register_extremes();
        test_random_traffic(0, 0, 3, 100);
        test_random_traffic(75, 0, 3, 100);
        test_random_traffic(0, 75, 3, 100);
        test_random_traffic(7, 7, 3, 100);
        test_output_backpressure();
        settle_pipeline();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== depth_pixel_backprojection.f =====
+incdir+design
design/dpb_pkg.sv
design/dpb_front.sv
design/dpb_lateral.sv
design/dpb_pose.sv
design/depth_pixel_backprojection.sv
design/dpb_checker.sv
dv/tb_depth_pixel_backprojection.sv
